### rtl/core/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;

    localparam int SAMPLE_W = 16;
    localparam int STD_W    = 15;
    localparam int COUNT_W  = 16;

    localparam int MAG_BITS   = SAMPLE_BITS + 1;
    localparam int SUM_BITS   = 32;
    localparam int SUMSQ_BITS = 48;
    localparam int PROD_BITS  = 64;
    localparam int MULB_BITS  = 32;
    localparam int DEN_BITS   = 32;
    localparam int ROOT_BITS  = PROD_BITS / 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] MIN_VALID = COUNT_BITS'(2);

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

### rtl/core/rsd_if.sv
`default_nettype none

interface rsd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rsd_out_if;
    logic                        valid;
    logic                        ready;
    logic [rsd_pkg::STD_W-1:0]   std_dev;
    logic                        dev_valid;
    logic                        saturated;
    logic [rsd_pkg::COUNT_W-1:0] sample_count;

    modport source (output valid, output std_dev, output dev_valid, output saturated,
                    output sample_count, input ready);
    modport sink   (input valid, input std_dev, input dev_valid, input saturated,
                    input sample_count, output ready);
endinterface

`default_nettype wire

### rtl/core/rsd_mul.sv
`default_nettype none

module rsd_mul (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rsd_pkg::PROD_BITS-1:0]   a,
    input  wire logic [rsd_pkg::MULB_BITS-1:0]   b,
    output logic      [rsd_pkg::PROD_BITS-1:0]   product,
    output rsd_pkg::unit_stat_t                  stat
);

    logic [rsd_pkg::PROD_BITS-1:0] a_reg;
    logic [rsd_pkg::MULB_BITS-1:0] b_reg;
    logic [rsd_pkg::PROD_BITS-1:0] acc_reg;
    logic                          busy_reg;
    logic                          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (b_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[rsd_pkg::PROD_BITS-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[rsd_pkg::MULB_BITS-1:1]};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### rtl/core/rsd_div.sv
`default_nettype none

module rsd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [rsd_pkg::PROD_BITS-1:0]  dividend,
    input  wire logic [rsd_pkg::DEN_BITS-1:0]   divisor,
    output logic      [rsd_pkg::PROD_BITS-1:0]  quotient,
    output rsd_pkg::unit_stat_t                 stat
);

    localparam int CNT_W = $clog2(rsd_pkg::PROD_BITS);

    logic [rsd_pkg::PROD_BITS-1:0] quo_reg;
    logic [rsd_pkg::DEN_BITS-1:0]  rem_reg;
    logic [rsd_pkg::DEN_BITS-1:0]  den_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [rsd_pkg::DEN_BITS:0]    shifted;
    logic [rsd_pkg::DEN_BITS:0]    diff;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[rsd_pkg::PROD_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
            cnt_reg <= CNT_W'(rsd_pkg::PROD_BITS - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[rsd_pkg::DEN_BITS-1:0] : shifted[rsd_pkg::DEN_BITS-1:0];
            quo_reg <= {quo_reg[rsd_pkg::PROD_BITS-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### rtl/core/rsd_sqrt.sv
`default_nettype none

module rsd_sqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [rsd_pkg::PROD_BITS-1:0]  radicand,
    output logic      [rsd_pkg::ROOT_BITS-1:0]  root,
    output rsd_pkg::unit_stat_t                 stat
);

    localparam int CNT_W = $clog2(rsd_pkg::ROOT_BITS);
    localparam int REM_W = rsd_pkg::ROOT_BITS + 2;
    localparam int TRY_W = REM_W + 2;

    logic [rsd_pkg::PROD_BITS-1:0] x_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [rsd_pkg::ROOT_BITS-1:0] root_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [TRY_W-1:0]              rem_shift;
    logic [TRY_W-1:0]              trial;
    logic                          fits;

    assign rem_shift = {rem_reg, x_reg[rsd_pkg::PROD_BITS-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CNT_W'(rsd_pkg::ROOT_BITS - 1);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_reg <= {root_reg[rsd_pkg::ROOT_BITS-2:0], fits};
            x_reg    <= {x_reg[rsd_pkg::PROD_BITS-3:0], 2'b00};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### rtl/core/running_standard_deviation.sv
`default_nettype none

// Channel   Dir   Interface    Payload
// in_ch     in    rsd_in_if    sample (16b signed)
// out_ch    out   rsd_out_if   std_dev (15b), dev_valid, saturated, sample_count (16b)
//
// One input transaction runs through the bit-serial shift-add multiplier (four products
// per sample once two samples are counted, else only the square), the 64-step serial
// divider and the 32-step serial square root; below two samples those two are skipped.
// Reset clears the running sum, sum of squares, sample count and both handshakes.
// A new sample is taken as soon as the previous result sits in the output register;
// a stalled output holds the finished result and delays the next completion and the next take.

module running_standard_deviation (
    input wire logic   clk,
    input wire logic   rst_n,
    rsd_in_if.sink     in_ch,
    rsd_out_if.source  out_ch
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_LHS  = 9'b000000100,
        S_SUM2 = 9'b000001000,
        S_NN   = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_SQRT = 9'b001000000,
        S_DONE = 9'b010000000,
        S_HOLD = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   go_reg;

    logic [rsd_pkg::MAG_BITS-1:0]   mag_reg;
    logic                           neg_reg;
    logic                           sat_reg;
    logic [rsd_pkg::SUM_BITS-1:0]   sum_reg;
    logic [rsd_pkg::SUMSQ_BITS-1:0] sumsq_reg;
    logic [rsd_pkg::COUNT_BITS-1:0] count_reg;
    logic [rsd_pkg::PROD_BITS-1:0]  num_reg;
    logic [rsd_pkg::DEN_BITS-1:0]   den_reg;
    logic [rsd_pkg::STD_W-1:0]      std_res_reg;
    logic                           vld_res_reg;

    logic                           out_valid_reg;
    logic [rsd_pkg::STD_W-1:0]      std_dev_reg;
    logic                           dev_valid_reg;
    logic                           sat_out_reg;
    logic [rsd_pkg::COUNT_BITS-1:0] count_out_reg;

    logic                           in_fire;
    logic                           out_fire;
    logic [rsd_pkg::SAMPLE_BITS-1:0] sample_raw;
    logic [rsd_pkg::MAG_BITS-1:0]   sample_ext;
    logic [rsd_pkg::MAG_BITS-1:0]   sample_mag;
    logic [rsd_pkg::COUNT_BITS-1:0] count_after;
    logic [rsd_pkg::SUM_BITS-1:0]   abs_sum;

    logic [rsd_pkg::PROD_BITS-1:0]  mul_a;
    logic [rsd_pkg::MULB_BITS-1:0]  mul_b;
    logic [rsd_pkg::PROD_BITS-1:0]  mul_p;
    logic                           mul_start;
    rsd_pkg::unit_stat_t            mul_stat;
    logic [rsd_pkg::PROD_BITS-1:0]  div_q;
    rsd_pkg::unit_stat_t            div_stat;
    logic [rsd_pkg::ROOT_BITS-1:0]  sqrt_root;
    rsd_pkg::unit_stat_t            sqrt_stat;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    assign sample_raw  = rsd_pkg::SAMPLE_BITS'(in_ch.sample);
    assign sample_ext  = {sample_raw[rsd_pkg::SAMPLE_BITS-1], sample_raw};
    assign sample_mag  = sample_raw[rsd_pkg::SAMPLE_BITS-1] ? (-sample_ext) : sample_ext;
    assign count_after = sat_reg ? count_reg : (count_reg + rsd_pkg::COUNT_BITS'(1));
    assign abs_sum     = sum_reg[rsd_pkg::SUM_BITS-1] ? (-sum_reg) : sum_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = rsd_pkg::PROD_BITS'(mag_reg);
                mul_b = rsd_pkg::MULB_BITS'(mag_reg);
            end
            S_LHS:
            begin
                mul_a = rsd_pkg::PROD_BITS'(sumsq_reg);
                mul_b = rsd_pkg::MULB_BITS'(count_reg);
            end
            S_SUM2:
            begin
                mul_a = rsd_pkg::PROD_BITS'(abs_sum);
                mul_b = rsd_pkg::MULB_BITS'(abs_sum);
            end
            S_NN:
            begin
                mul_a = rsd_pkg::PROD_BITS'(count_reg);
                mul_b = rsd_pkg::MULB_BITS'(count_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = go_reg && ((state_reg == S_SQ) || (state_reg == S_LHS) ||
                                  (state_reg == S_SUM2) || (state_reg == S_NN));

    rsd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    rsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg && (state_reg == S_DIV)),
        .dividend (num_reg),
        .divisor  (den_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    rsd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg && (state_reg == S_SQRT)),
        .radicand (num_reg),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (mul_stat.done)
                begin
                    state_next = (count_after >= rsd_pkg::MIN_VALID) ? S_LHS : S_DONE;
                end
            end
            S_LHS:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_SUM2;
                end
            end
            S_SUM2:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_NN;
                end
            end
            S_NN:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg);
            if ((state_reg == S_SQ) && mul_stat.done && !sat_reg)
            begin
                sum_reg   <= neg_reg ? (sum_reg - rsd_pkg::SUM_BITS'(mag_reg))
                                     : (sum_reg + rsd_pkg::SUM_BITS'(mag_reg));
                sumsq_reg <= sumsq_reg + mul_p[rsd_pkg::SUMSQ_BITS-1:0];
                count_reg <= count_after;
            end
            if ((state_reg == S_HOLD) && (state_next == S_IDLE))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mag_reg <= sample_mag;
            neg_reg <= sample_raw[rsd_pkg::SAMPLE_BITS-1];
            sat_reg <= (count_reg == rsd_pkg::COUNT_MAX);
        end
        if ((state_reg == S_SQ) && mul_stat.done)
        begin
            std_res_reg <= '0;
            vld_res_reg <= 1'b0;
        end
        if ((state_reg == S_LHS) && mul_stat.done)
        begin
            num_reg <= mul_p;
        end
        if ((state_reg == S_SUM2) && mul_stat.done)
        begin
            num_reg <= (num_reg > mul_p) ? (num_reg - mul_p) : '0;
        end
        if ((state_reg == S_NN) && mul_stat.done)
        begin
            den_reg <= mul_p[rsd_pkg::DEN_BITS-1:0];
        end
        if ((state_reg == S_DIV) && div_stat.done)
        begin
            num_reg <= div_q;
        end
        if ((state_reg == S_SQRT) && sqrt_stat.done)
        begin
            std_res_reg <= (|sqrt_root[rsd_pkg::ROOT_BITS-1:rsd_pkg::STD_W]) ? '1
                           : sqrt_root[rsd_pkg::STD_W-1:0];
            vld_res_reg <= 1'b1;
        end
        if ((state_reg == S_HOLD) && (state_next == S_IDLE))
        begin
            std_dev_reg   <= std_res_reg;
            dev_valid_reg <= vld_res_reg;
            sat_out_reg   <= sat_reg;
            count_out_reg <= count_reg;
        end
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.std_dev      = std_dev_reg;
    assign out_ch.dev_valid    = dev_valid_reg;
    assign out_ch.saturated    = sat_out_reg;
    assign out_ch.sample_count = rsd_pkg::COUNT_W'(count_out_reg);

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.dev_valid == (out_ch.sample_count >= rsd_pkg::COUNT_W'(2))))
        else $error("dev_valid disagrees with sample_count");

    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.dev_valid) |-> (out_ch.std_dev == '0))
        else $error("std_dev nonzero without a valid deviation");

    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.saturated) |->
            (out_ch.sample_count == rsd_pkg::COUNT_W'(rsd_pkg::COUNT_MAX)))
        else $error("saturated reported below the full count");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_stat.busy, div_stat.busy, sqrt_stat.busy}))
        else $error("more than one arithmetic unit busy");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == ($past(count_reg) + rsd_pkg::COUNT_BITS'(1))))
        else $error("sample count moved by other than one");

endmodule

`default_nettype wire
